// File: rtl/core/nnls_pkg.sv
// Shared types and constants of the letterbox scaler core.
// Depends on nothing; every other file of the core imports it.
`timescale 1ns / 1ps

package nnls_pkg;

   localparam int DimW       = 13;
   localparam int CoordW     = 12;
   localparam int IdxW       = 16;
   localparam int PixW       = 32;
   localparam int CsrIdxW    = 3;
   localparam int ProdW      = 2 * DimW;
   localparam int QueueDepth = 4;
   localparam int OutDepth   = 32;

   localparam logic [DimW-1:0] MAX_DIM     = 13'd4096;
   localparam logic [PixW-1:0] BG_RESET    = 32'hFF0F1116;
   localparam logic [DimW-1:0] FB_W_RESET  = 13'd640;
   localparam logic [DimW-1:0] FB_H_RESET  = 13'd480;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SCREEN_W = 3'd0,
      CSR_SCREEN_H = 3'd1,
      CSR_IMAGE_W  = 3'd2,
      CSR_IMAGE_H  = 3'd3,
      CSR_BG_COLOR = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_RENDER = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      G_IDLE,
      G_MUL,
      G_SEL,
      G_DIV,
      G_FIN,
      G_OFS
   } geom_state_type;

   // Display geometry, settled after every register write
   typedef struct packed {
      logic              blank;
      logic [DimW-1:0]   fw;
      logic [DimW-1:0]   fh;
      logic [DimW-1:0]   iw;
      logic [DimW-1:0]   ih;
      logic [DimW-1:0]   dw;
      logic [DimW-1:0]   dh;
      logic [CoordW-1:0] ox;
      logic [CoordW-1:0] oy;
      logic [PixW-1:0]   bg_color;
   } geom_type;

   // One classified transaction between front and back
   typedef struct packed {
      logic              render;
      logic              bg;
      logic [IdxW-1:0]   addr;
      logic [PixW-1:0]   data;
      logic [CoordW-1:0] rx;
      logic [CoordW-1:0] ry;
   } entry_type;

endpackage

// File: rtl/core/nnls_geom.sv
// Configuration registers and the display geometry sequencer.
// Depends on nnls_pkg; computes display size with one serial divider.
`timescale 1ns / 1ps

module nnls_geom import nnls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [PixW-1:0]    csr_data,
   output geom_type           geom,
   output logic               busy
);

   logic [DimW-1:0]  fw_ff, fh_ff, iw_ff, ih_ff;
   logic [PixW-1:0]  bg_ff;
   geom_state_type   state_ff, state_in;
   logic [ProdW-1:0] p1_ff, p2_ff, num_ff, q_ff;
   logic             wlim_ff;
   logic [DimW-1:0]  rem_ff;
   logic [4:0]       cnt_ff;
   logic [DimW-1:0]  dw_ff, dh_ff;
   logic [CoordW-1:0] ox_ff, oy_ff;
   logic [DimW-1:0]  divisor;
   logic [DimW:0]    trial;
   logic             csr_wr;

   function automatic logic [DimW-1:0] sat_dim(input logic [PixW-1:0] v);
      sat_dim = (v[DimW-1:0] > MAX_DIM) ? MAX_DIM : v[DimW-1:0];
   endfunction

   function automatic logic [DimW-1:0] clamp_disp(input logic [ProdW-1:0] q,
                                                  input logic [DimW-1:0] lim);
      if (q == '0)
         clamp_disp = DimW'(1);
      else if (q > ProdW'(lim))
         clamp_disp = lim;
      else
         clamp_disp = q[DimW-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // Hold register values; dimensions keep their low DimW bits, saturated at MAX_DIM
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FB_W_RESET;
         fh_ff <= FB_H_RESET;
         iw_ff <= '0;
         ih_ff <= '0;
         bg_ff <= BG_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_SCREEN_W: fw_ff <= sat_dim(csr_data);
            CSR_SCREEN_H: fh_ff <= sat_dim(csr_data);
            CSR_IMAGE_W:  iw_ff <= sat_dim(csr_data);
            CSR_IMAGE_H:  ih_ff <= sat_dim(csr_data);
            CSR_BG_COLOR: bg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= G_MUL;
      else
         state_ff <= state_in;
   end

   // Restart on any write, otherwise step through the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         G_IDLE: state_in = G_IDLE;
         G_MUL:  state_in = G_SEL;
         G_SEL:  state_in = G_DIV;
         G_DIV:  state_in = (cnt_ff == 5'(ProdW - 1)) ? G_FIN : G_DIV;
         G_FIN:  state_in = G_OFS;
         G_OFS:  state_in = G_IDLE;
         default: state_in = G_IDLE;
      endcase
      if (csr_wr)
         state_in = G_MUL;
   end

   assign divisor = wlim_ff ? iw_ff : ih_ff;
   assign trial   = {rem_ff, num_ff[ProdW-1]};

   // Cross-multiply, divide one bit per cycle, clamp, centre
   always_ff @(posedge clock) begin
      case (state_ff)
         G_MUL: begin
            p1_ff <= fw_ff * ih_ff;
            p2_ff <= fh_ff * iw_ff;
         end
         G_SEL: begin
            wlim_ff <= (p1_ff <= p2_ff);
            num_ff  <= (p1_ff <= p2_ff) ? p1_ff : p2_ff;
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= '0;
         end
         G_DIV: begin
            num_ff <= {num_ff[ProdW-2:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (trial >= {1'b0, divisor}) begin
               rem_ff <= DimW'(trial - {1'b0, divisor});
               q_ff   <= {q_ff[ProdW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DimW-1:0];
               q_ff   <= {q_ff[ProdW-2:0], 1'b0};
            end
         end
         G_FIN: begin
            dw_ff <= wlim_ff ? fw_ff : clamp_disp(q_ff, fw_ff);
            dh_ff <= wlim_ff ? clamp_disp(q_ff, fh_ff) : fh_ff;
         end
         G_OFS: begin
            ox_ff <= CoordW'((fw_ff - dw_ff) >> 1);
            oy_ff <= CoordW'((fh_ff - dh_ff) >> 1);
         end
         default: ;
      endcase
   end

   assign busy          = (state_ff != G_IDLE);
   assign geom.blank    = (fw_ff == '0) | (fh_ff == '0) | (iw_ff == '0) | (ih_ff == '0);
   assign geom.fw       = fw_ff;
   assign geom.fh       = fh_ff;
   assign geom.iw       = iw_ff;
   assign geom.ih       = ih_ff;
   assign geom.dw       = dw_ff;
   assign geom.dh       = dh_ff;
   assign geom.ox       = ox_ff;
   assign geom.oy       = oy_ff;
   assign geom.bg_color = bg_ff;

   a_geom_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == G_IDLE && !geom.blank) |->
         (dw_ff >= DimW'(1) && dw_ff <= fw_ff && dh_ff >= DimW'(1) && dh_ff <= fh_ff))
      else $error("display size outside framebuffer");

endmodule

// File: rtl/core/nnls_front.sv
// Front end: accepts transactions, classifies renders, queues all transactions.
// Depends on nnls_pkg and the geometry from nnls_geom.
`timescale 1ns / 1ps

module nnls_front import nnls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_command,
   input  logic [IdxW-1:0]   req_source_index,
   input  logic [PixW-1:0]   req_source_pixel,
   input  logic [CoordW-1:0] req_screen_x,
   input  logic [CoordW-1:0] req_screen_y,
   input  geom_type          geom,
   input  logic              busy,
   output logic              q_valid,
   output entry_type         q_head,
   input  logic              q_pop
);

   entry_type       queue_ff [QueueDepth];
   logic [1:0]      wptr_ff, rptr_ff;
   logic [2:0]      cnt_ff;
   logic            push;
   entry_type       entry;
   logic [DimW-1:0] x_ext, y_ext;
   logic            outside;

   assign req_full = (cnt_ff == 3'(QueueDepth)) | busy;
   assign push     = req_push & ~req_full;

   // Classify against framebuffer and displayed area
   always_comb begin
      x_ext   = {1'b0, req_screen_x};
      y_ext   = {1'b0, req_screen_y};
      outside = geom.blank
              | (x_ext >= geom.fw) | (y_ext >= geom.fh)
              | (req_screen_x < geom.ox) | (req_screen_y < geom.oy)
              | (x_ext >= ({1'b0, geom.ox} + geom.dw))
              | (y_ext >= ({1'b0, geom.oy} + geom.dh));
      entry.render = (cmd_type'(req_command) == CMD_RENDER);
      entry.bg     = outside;
      entry.addr   = req_source_index;
      entry.data   = req_source_pixel;
      entry.rx     = req_screen_x - geom.ox;
      entry.ry     = req_screen_y - geom.oy;
   end

   always_ff @(posedge clock) begin
      if (push)
         queue_ff[wptr_ff] <= entry;
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push)
            wptr_ff <= wptr_ff + 2'd1;
         if (q_pop)
            rptr_ff <= rptr_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(q_pop);
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_head  = queue_ff[rptr_ff];

   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

// File: rtl/core/nnls_back.sv
// Back end: pipelined nearest-neighbour divide, image store, result queue.
// Depends on nnls_pkg; takes transactions from nnls_front.
`timescale 1ns / 1ps

module nnls_back import nnls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  entry_type       q_head,
   output logic            q_pop,
   input  geom_type        geom,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [PixW-1:0] rsp_color,
   output logic            rsp_is_background
);

   localparam int NumW  = CoordW + DimW;
   localparam int Steps = DimW;

   typedef struct packed {
      logic            v;
      logic            render;
      logic            bg;
      logic [IdxW-1:0] addr;
      logic [PixW-1:0] data;
      logic [NumW-1:0] nx;
      logic [NumW-1:0] ny;
   } mul_stage_type;

   typedef struct packed {
      logic            v;
      logic            render;
      logic            bg;
      logic [IdxW-1:0] addr;
      logic [PixW-1:0] data;
      logic [DimW-1:0] remx;
      logic [DimW-1:0] lowx;
      logic [DimW-1:0] qx;
      logic [DimW-1:0] remy;
      logic [DimW-1:0] lowy;
      logic [DimW-1:0] qy;
   } div_stage_type;

   typedef struct packed {
      logic            v;
      logic            render;
      logic            bg;
      logic [IdxW-1:0] addr;
      logic [PixW-1:0] data;
   } mem_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s,
                                              input logic [DimW-1:0] dx,
                                              input logic [DimW-1:0] dy);
      logic [DimW:0] tx, ty;
      div_stage_type r;
      r      = s;
      tx     = {s.remx, s.lowx[DimW-1]};
      ty     = {s.remy, s.lowy[DimW-1]};
      r.lowx = {s.lowx[DimW-2:0], 1'b0};
      r.lowy = {s.lowy[DimW-2:0], 1'b0};
      if (tx >= {1'b0, dx}) begin
         r.remx = DimW'(tx - {1'b0, dx});
         r.qx   = {s.qx[DimW-2:0], 1'b1};
      end else begin
         r.remx = tx[DimW-1:0];
         r.qx   = {s.qx[DimW-2:0], 1'b0};
      end
      if (ty >= {1'b0, dy}) begin
         r.remy = DimW'(ty - {1'b0, dy});
         r.qy   = {s.qy[DimW-2:0], 1'b1};
      end else begin
         r.remy = ty[DimW-1:0];
         r.qy   = {s.qy[DimW-2:0], 1'b0};
      end
      return r;
   endfunction

   mul_stage_type   mul_ff;
   div_stage_type   div_ff [Steps+1];
   mem_stage_type   idx_ff, rd_meta_ff;
   logic [PixW-1:0] rd_ff;
   logic [PixW-1:0] mem [1 << IdxW];
   logic [PixW:0]   out_ff [OutDepth];
   logic [4:0]      owptr_ff, orptr_ff;
   logic [5:0]      ocnt_ff, inflight_ff;
   logic            credit_ok, out_wr, out_rd, pop_render;
   logic [ProdW-1:0] row_base;

   // Issue a render only when the result queue has room reserved for it
   assign credit_ok  = ({1'b0, inflight_ff} + {1'b0, ocnt_ff}) < 7'(OutDepth);
   assign q_pop      = q_valid & (~q_head.render | credit_ok);
   assign pop_render = q_pop & q_head.render;

   // Advance valid bits; scale offsets by image size, then divide one quotient bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.v     <= 1'b0;
         idx_ff.v     <= 1'b0;
         rd_meta_ff.v <= 1'b0;
         for (int i = 0; i <= Steps; i++)
            div_ff[i].v <= 1'b0;
      end else begin
         mul_ff.v     <= q_pop;
         div_ff[0].v  <= mul_ff.v;
         for (int i = 0; i < Steps; i++)
            div_ff[i+1].v <= div_ff[i].v;
         idx_ff.v     <= div_ff[Steps].v;
         rd_meta_ff.v <= idx_ff.v;
      end

      mul_ff.render <= q_head.render;
      mul_ff.bg     <= q_head.bg;
      mul_ff.addr   <= q_head.addr;
      mul_ff.data   <= q_head.data;
      mul_ff.nx     <= q_head.rx * geom.iw;
      mul_ff.ny     <= q_head.ry * geom.ih;

      div_ff[0].render <= mul_ff.render;
      div_ff[0].bg     <= mul_ff.bg;
      div_ff[0].addr   <= mul_ff.addr;
      div_ff[0].data   <= mul_ff.data;
      div_ff[0].remx   <= {1'b0, mul_ff.nx[NumW-1:DimW]};
      div_ff[0].lowx   <= mul_ff.nx[DimW-1:0];
      div_ff[0].qx     <= '0;
      div_ff[0].remy   <= {1'b0, mul_ff.ny[NumW-1:DimW]};
      div_ff[0].lowy   <= mul_ff.ny[DimW-1:0];
      div_ff[0].qy     <= '0;

      for (int i = 0; i < Steps; i++) begin
         div_ff[i+1].render <= div_ff[i].render;
         div_ff[i+1].bg     <= div_ff[i].bg;
         div_ff[i+1].addr   <= div_ff[i].addr;
         div_ff[i+1].data   <= div_ff[i].data;
         {div_ff[i+1].remx, div_ff[i+1].lowx, div_ff[i+1].qx,
          div_ff[i+1].remy, div_ff[i+1].lowy, div_ff[i+1].qy} <=
            {div_step(div_ff[i], geom.dw, geom.dh).remx,
             div_step(div_ff[i], geom.dw, geom.dh).lowx,
             div_step(div_ff[i], geom.dw, geom.dh).qx,
             div_step(div_ff[i], geom.dw, geom.dh).remy,
             div_step(div_ff[i], geom.dw, geom.dh).lowy,
             div_step(div_ff[i], geom.dw, geom.dh).qy};
      end
   end

   // Form the row-major store address, wrapping at the store size
   assign row_base = div_ff[Steps].qy * geom.iw;

   always_ff @(posedge clock) begin
      idx_ff.render <= div_ff[Steps].render;
      idx_ff.bg     <= div_ff[Steps].bg;
      idx_ff.data   <= div_ff[Steps].data;
      idx_ff.addr   <= div_ff[Steps].render
                     ? IdxW'(row_base + ProdW'(div_ff[Steps].qx))
                     : div_ff[Steps].addr;
   end

   // Image store: loads write, renders read, in transaction order
   always_ff @(posedge clock) begin
      if (idx_ff.v & ~idx_ff.render)
         mem[idx_ff.addr] <= idx_ff.data;
      rd_ff <= mem[idx_ff.addr];
   end

   always_ff @(posedge clock) begin
      rd_meta_ff.render <= idx_ff.render;
      rd_meta_ff.bg     <= idx_ff.bg;
      rd_meta_ff.addr   <= idx_ff.addr;
      rd_meta_ff.data   <= idx_ff.data;
   end

   // Result queue
   assign out_wr = rd_meta_ff.v & rd_meta_ff.render;
   assign out_rd = rsp_pop & ~rsp_empty;

   always_ff @(posedge clock) begin
      if (out_wr)
         out_ff[owptr_ff] <= {rd_meta_ff.bg, rd_meta_ff.bg ? geom.bg_color : rd_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff    <= '0;
         orptr_ff    <= '0;
         ocnt_ff     <= '0;
         inflight_ff <= '0;
      end else begin
         if (out_wr)
            owptr_ff <= owptr_ff + 5'd1;
         if (out_rd)
            orptr_ff <= orptr_ff + 5'd1;
         ocnt_ff     <= ocnt_ff + 6'(out_wr) - 6'(out_rd);
         inflight_ff <= inflight_ff + 6'(pop_render) - 6'(out_wr);
      end
   end

   assign rsp_empty         = (ocnt_ff == '0);
   assign rsp_color         = out_ff[orptr_ff][PixW-1:0];
   assign rsp_is_background = out_ff[orptr_ff][PixW];

   a_credit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, inflight_ff} + {1'b0, ocnt_ff}) <= 7'(OutDepth))
      else $error("result queue overcommitted");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_wr |-> (ocnt_ff != 6'(OutDepth) || out_rd))
      else $error("result written into full queue");

endmodule

// File: rtl/core/nearest_neighbor_letterbox_scaler_core.sv
// Letterbox scaler core: an ARGB image store with nearest-neighbour output.
// Usage:
//   req_*  : queue-style input. A transaction is taken when req_push is high
//            and req_full low. Command load writes req_source_pixel at
//            req_source_index; command render asks for pixel
//            (req_screen_x, req_screen_y) and yields one result.
//   rsp_*  : queue-style output. The oldest result is shown while rsp_empty
//            is low and leaves when rsp_pop is high.
//   csr_*  : register writes, always ready. After each write the display
//            geometry is recomputed (two multiplies, a 26-step serial divide,
//            clamp and centring); req_full stays high meanwhile.
// Throughput is one transaction per cycle while req_full is low. A render
// result passes the queue, multiply, 13 divider stages, address and store read.
// A stalled receiver fills the 32-entry result queue; renders are held in the
// 4-entry transaction queue and then req_full rises, with no result lost.
// Reset restores the register defaults, empties both queues and runs the
// geometry sequence once; the image store is not cleared.
// Depends on nnls_pkg, nnls_geom, nnls_front and nnls_back.
`timescale 1ns / 1ps

module nearest_neighbor_letterbox_scaler_core import nnls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_command,
   input  logic [IdxW-1:0]    req_source_index,
   input  logic [PixW-1:0]    req_source_pixel,
   input  logic [CoordW-1:0]  req_screen_x,
   input  logic [CoordW-1:0]  req_screen_y,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [PixW-1:0]    rsp_color,
   output logic               rsp_is_background,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [PixW-1:0]    csr_data
);

   geom_type  geom;
   logic      busy;
   logic      q_valid, q_pop;
   entry_type q_head;

   nnls_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .busy      (busy)
   );

   nnls_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_source_index (req_source_index),
      .req_source_pixel (req_source_pixel),
      .req_screen_x     (req_screen_x),
      .req_screen_y     (req_screen_y),
      .geom             (geom),
      .busy             (busy),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop)
   );

   nnls_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .geom              (geom),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_color         (rsp_color),
      .rsp_is_background (rsp_is_background)
   );

endmodule
